[hw/rtl/radix2_dif_fft_defines.svh]
// assertion macros
`ifndef RADIX2_DIF_FFT_DEFINES_SVH
`define RADIX2_DIF_FFT_DEFINES_SVH
`define R2F_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define R2F_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

[hw/rtl/r2f_pkg.sv]
`default_nettype none
package r2f_pkg;
  localparam int MaxPoints = 1024;
  localparam int AddrW = $clog2(MaxPoints);
  localparam int TwAddrW = AddrW - 1;
  localparam int LgW = 4;
  localparam int DataW = 28;

  typedef enum logic [1:0] {
    CMD_LOAD_SAMPLE = 2'd0,
    CMD_LOAD_TWIDDLE = 2'd1,
    CMD_RUN = 2'd2,
    CMD_READ = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [9:0] index;
    logic signed [15:0] data_re;
    logic signed [15:0] data_im;
  } in_item_t;

  typedef struct packed {
    logic kind;
    logic [9:0] out_index;
    logic signed [27:0] out_re;
    logic signed [27:0] out_im;
  } out_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] re;
    logic signed [DataW-1:0] im;
  } cplx_t;

  function automatic logic [AddrW-1:0] bit_rev(input logic [AddrW-1:0] k,
                                               input logic [LgW-1:0] lg);
    logic [AddrW-1:0] r;
    r = '0;
    for (int i = 0; i < AddrW; i++) begin
      if (i < int'(lg)) r[int'(lg) - 1 - i] = k[i];
    end
    return r;
  endfunction
endpackage
`default_nettype wire

[hw/rtl/radix2_dif_fft.sv]
`default_nettype none
// channel  direction  handshake
// in_      input      in_valid / in_stall
// out_     output     out_valid / out_stall
// cfg_     input      cfg_valid / cfg_ready
// loads are taken in IDLE; a read steps through RD and RDW; a run steps through A, B, LAT,
// M1, WP and WQ for each of its (N/2)log2N butterflies: one sample memory port
// reset is synchronous active low; memories are not cleared
// results wait in an output register; a pending result stalls the input
module radix2_dif_fft
  import r2f_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [3:0] cfg_data
);
  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001, ST_RD   = 9'b000000010, ST_RDW  = 9'b000000100,
    ST_A    = 9'b000001000, ST_B    = 9'b000010000, ST_LAT  = 9'b000100000,
    ST_M1   = 9'b001000000, ST_WP   = 9'b010000000, ST_WQ   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [LgW-1:0] lg_cfg_r, lg;
  cplx_t smem [MaxPoints];
  logic [31:0] tmem [MaxPoints/2];
  cplx_t rd_r, a_r, b_r, sum_r, prod_r;
  logic [31:0] tw_rd_r;
  logic [AddrW-1:0] addr, p_addr, q_addr, half, k_r;
  logic [LgW-1:0] stage_r;
  logic [AddrW-1:0] cnt_r;
  logic we;
  cplx_t wdata;
  logic [TwAddrW-1:0] t_addr;
  logic in_acc, last_b;
  out_item_t res_nxt;
  logic res_load;

  assign cfg_ready = 1'b1;
  assign lg = (lg_cfg_r == '0) ? LgW'(1) : (lg_cfg_r > LgW'(AddrW)) ? LgW'(AddrW) : lg_cfg_r;
  assign in_stall = (state_r != ST_IDLE) || out_valid;
  assign in_acc = in_valid && !in_stall;

  // butterfly address from counter: insert a zero bit at log position
  assign half = AddrW'((AddrW+1)'(1) << (lg - stage_r - LgW'(1)));
  assign p_addr = ((cnt_r & ~(half - AddrW'(1))) << 1) | (cnt_r & (half - AddrW'(1)));
  assign q_addr = p_addr | half;
  assign t_addr = TwAddrW'((cnt_r & (half - AddrW'(1))) << stage_r);
  assign last_b = (cnt_r == ((AddrW'(1) << (lg - LgW'(1))) - AddrW'(1)));

  always_comb begin
    addr = p_addr;
    we = 1'b0;
    wdata = sum_r;
    case (state_r)
      ST_IDLE: begin
        addr = in_item.cmd == CMD_READ
          ? bit_rev(in_item.index & ((AddrW'(1) << lg) - AddrW'(1)), lg)
          : in_item.index;
        we = in_acc && in_item.cmd == CMD_LOAD_SAMPLE;
        wdata.re = DataW'(in_item.data_re);
        wdata.im = DataW'(in_item.data_im);
      end
      ST_A: addr = p_addr;
      ST_B: addr = q_addr;
      ST_WP: begin addr = p_addr; we = 1'b1; wdata = sum_r; end
      ST_WQ: begin addr = q_addr; we = 1'b1; wdata = prod_r; end
      default: addr = p_addr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) smem[addr] <= wdata;
    // read data held through state RD, so RDW sees the word read in IDLE
    if (state_r != ST_RD) rd_r <= smem[addr];
    if (state_r == ST_IDLE && in_acc && in_item.cmd == CMD_LOAD_TWIDDLE)
      tmem[in_item.index[TwAddrW-1:0]] <= {in_item.data_re, in_item.data_im};
    tw_rd_r <= tmem[t_addr];
    if (state_r == ST_B) a_r <= rd_r;
    if (state_r == ST_LAT) b_r <= rd_r;
    if (state_r == ST_IDLE) k_r <= in_item.index & ((AddrW'(1) << lg) - AddrW'(1));
  end

  r2f_bfly u_bfly (
    .clk(clk), .a(a_r), .b(b_r),
    .wr(tw_rd_r[31:16]), .wi(tw_rd_r[15:0]),
    .sum_r(sum_r), .prod_r(prod_r)
  );

  always_comb begin
    state_nxt = state_r;
    res_load = 1'b0;
    res_nxt = '0;
    case (state_r)
      ST_IDLE: if (in_acc) begin
        if (in_item.cmd == CMD_READ) state_nxt = ST_RD;
        else if (in_item.cmd == CMD_RUN) state_nxt = ST_A;
      end
      ST_RD: state_nxt = ST_RDW;
      ST_RDW: begin
        res_load = 1'b1;
        res_nxt.out_index = k_r;
        res_nxt.out_re = rd_r.re;
        res_nxt.out_im = rd_r.im;
        state_nxt = ST_IDLE;
      end
      ST_A: state_nxt = ST_B;
      ST_B: state_nxt = ST_LAT;
      ST_LAT: state_nxt = ST_M1;
      ST_M1: state_nxt = ST_WP;
      ST_WP: state_nxt = ST_WQ;
      ST_WQ: begin
        if (last_b && stage_r == lg - LgW'(1)) begin
          res_load = 1'b1;
          res_nxt.kind = 1'b1;
          state_nxt = ST_IDLE;
        end else state_nxt = ST_A;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lg_cfg_r <= LgW'(AddrW);
      out_valid <= 1'b0;
      stage_r <= '0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) lg_cfg_r <= cfg_data;
      if (res_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (state_r == ST_IDLE) begin
        stage_r <= '0;
        cnt_r <= '0;
      end else if (state_r == ST_WQ) begin
        if (last_b) begin
          cnt_r <= '0;
          stage_r <= stage_r + LgW'(1);
        end else cnt_r <= cnt_r + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) out_item <= res_nxt;
  end
endmodule
`default_nettype wire

[hw/rtl/r2f_bfly.sv]
`default_nettype none
// butterfly with registered products and sum: sum, and difference times twiddle
module r2f_bfly
  import r2f_pkg::*;
(
  input  wire logic               clk,
  input  wire cplx_t              a,
  input  wire cplx_t              b,
  input  wire logic signed [15:0] wr,
  input  wire logic signed [15:0] wi,
  output cplx_t                   sum_r,
  output cplx_t                   prod_r
);
  logic signed [DataW:0] dr, di;
  logic signed [DataW+17:0] p_re, p_im;
  logic signed [DataW+16:0] m_rr, m_ii, m_ri, m_ir;
  cplx_t sum_nxt;
  logic signed [DataW+16:0] m_rr_r, m_ii_r, m_ri_r, m_ir_r;

  // difference kept one bit wider so it never wraps
  assign dr = {a.re[DataW-1], a.re} - {b.re[DataW-1], b.re};
  assign di = {a.im[DataW-1], a.im} - {b.im[DataW-1], b.im};
  assign m_rr = dr * wr;
  assign m_ii = di * wi;
  assign m_ri = dr * wi;
  assign m_ir = di * wr;
  assign sum_nxt.re = a.re + b.re;
  assign sum_nxt.im = a.im + b.im;

  always_ff @(posedge clk) begin
    m_rr_r <= m_rr;
    m_ii_r <= m_ii;
    m_ri_r <= m_ri;
    m_ir_r <= m_ir;
    sum_r  <= sum_nxt;
  end

  assign p_re = {m_rr_r[DataW+16], m_rr_r} - {m_ii_r[DataW+16], m_ii_r};
  assign p_im = {m_ri_r[DataW+16], m_ri_r} + {m_ir_r[DataW+16], m_ir_r};
  assign prod_r.re = p_re[DataW+14:15];
  assign prod_r.im = p_im[DataW+14:15];
endmodule
`default_nettype wire

[hw/rtl/r2f_checker.sv]
`default_nettype none
`include "radix2_dif_fft_defines.svh"
module r2f_checker
  import r2f_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_item,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);
  `R2F_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled item changed")
  `R2F_ASSERT_NEXT(a_load_silent, in_valid && !in_stall && !in_item.cmd[1], !out_valid, "load gave an item")
  `R2F_ASSERT_IMPL(a_busy, out_valid, in_stall, "input taken while output pending")
  `R2F_ASSERT_IMPL(a_ack_zero, out_valid && out_item.kind, out_item.out_re == 0 && out_item.out_im == 0, "ack not zero")
endmodule
bind radix2_dif_fft r2f_checker u_r2f_checker (.*);
`default_nettype wire

[dv/tb.sv]
`default_nettype none
module tb;
  import r2f_pkg::*;

  class fft_scoreboard;
    logic signed [27:0] bin_re[MaxPoints];
    logic signed [27:0] bin_im[MaxPoints];
    logic signed [15:0] tw_re[MaxPoints/2];
    logic signed [15:0] tw_im[MaxPoints/2];
    logic [3:0] len_log2;
    out_item_t pending[$];
    int errors;

    function new();
      len_log2 = 4'd10;
      errors = 0;
      for (int i = 0; i < MaxPoints; i++) begin
        bin_re[i] = '0;
        bin_im[i] = '0;
      end
      for (int i = 0; i < MaxPoints/2; i++) begin
        tw_re[i] = '0;
        tw_im[i] = '0;
      end
    endfunction

    function int stages();
      int lg;
      lg = len_log2;
      if (lg < 1) lg = 1;
      if (lg > AddrW) lg = AddrW;
      return lg;
    endfunction

    function int reverse_bits(int k, int bits);
      int r;
      r = 0;
      for (int i = 0; i < bits; i++) r |= ((k >> i) & 1) << (bits - 1 - i);
      return r;
    endfunction

    function void transform();
      int lg, half, groups, stride, base, p, q, t;
      longint ar, ai, br, bi, dr, di, wr, wi, prod;
      lg = stages();
      half = (1 << lg) >> 1;
      groups = 1;
      stride = 1;
      for (int s = 0; s < lg; s++) begin
        for (int g = 0; g < groups; g++) begin
          base = g * (half << 1);
          for (int b = 0; b < half; b++) begin
            p = (base + b) % MaxPoints;
            q = (p + half) % MaxPoints;
            t = (b * stride) % (MaxPoints/2);
            ar = bin_re[p]; ai = bin_im[p];
            br = bin_re[q]; bi = bin_im[q];
            dr = ar - br; di = ai - bi;
            wr = tw_re[t]; wi = tw_im[t];
            prod = ar + br; bin_re[p] = prod[27:0];
            prod = ai + bi; bin_im[p] = prod[27:0];
            prod = (dr * wr - di * wi) >>> 15; bin_re[q] = prod[27:0];
            prod = (dr * wi + di * wr) >>> 15; bin_im[q] = prod[27:0];
          end
        end
        half >>= 1;
        groups <<= 1;
        stride <<= 1;
      end
    endfunction

    function void note_input(in_item_t it);
      out_item_t res;
      int lg, k, a;
      res = '0;
      case (cmd_t'(it.cmd))
        CMD_LOAD_SAMPLE: begin
          bin_re[it.index] = 28'(it.data_re);
          bin_im[it.index] = 28'(it.data_im);
        end
        CMD_LOAD_TWIDDLE: begin
          tw_re[it.index % (MaxPoints/2)] = it.data_re;
          tw_im[it.index % (MaxPoints/2)] = it.data_im;
        end
        CMD_RUN: begin
          transform();
          res.kind = 1'b1;
          pending.push_back(res);
        end
        default: begin
          lg = stages();
          k = it.index & ((1 << lg) - 1);
          a = reverse_bits(k, lg);
          res.out_index = 10'(k);
          res.out_re = bin_re[a];
          res.out_im = bin_im[a];
          pending.push_back(res);
        end
      endcase
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected item %h", got));
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind got %0d want %0d", got.kind, want.kind));
      if (got.out_index !== want.out_index)
        report($sformatf("bin got %0d want %0d", got.out_index, want.out_index));
      if (got.out_re !== want.out_re)
        report($sformatf("bin %0d re got %0d want %0d", want.out_index, got.out_re,
                         want.out_re));
      if (got.out_im !== want.out_im)
        report($sformatf("bin %0d im got %0d want %0d", want.out_index, got.out_im,
                         want.out_im));
    endtask
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_item_t in_item;
  out_item_t out_item;
  logic [3:0] cfg_data;

  fft_scoreboard sb;
  bit sample_written[MaxPoints];
  bit twiddle_written[MaxPoints/2];
  int items_sent, burst_left, stall_ctr;
  longint cycles;

  radix2_dif_fft dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stall pattern: clear, random, then long blocks
  always @(posedge clk) begin
    stall_ctr++;
    if (stall_ctr % 600 < 150) begin
      out_stall <= 1'b0;
    end else if (stall_ctr % 600 < 420) begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end else begin
      out_stall <= ((stall_ctr / 13) % 2) == 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(cmd_t c, int idx, logic signed [15:0] re, logic signed [15:0] im);
    in_item_t it;
    int gap;
    it.cmd = c;
    it.index = 10'(idx);
    it.data_re = re;
    it.data_im = im;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic load_sample(int idx);
    send_item(CMD_LOAD_SAMPLE, idx, pick_value(), pick_value());
    sample_written[idx] = 1'b1;
  endtask

  task automatic load_twiddle(int idx);
    send_item(CMD_LOAD_TWIDDLE, idx, pick_value(), pick_value());
    twiddle_written[idx % (MaxPoints/2)] = 1'b1;
  endtask

  task automatic set_length(logic [3:0] v);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.len_log2 = v;
  endtask

  task automatic random_read(int lg);
    int k;
    k = $urandom_range(0, 1023);
    if (!sample_written[sb.reverse_bits(k & ((1 << lg) - 1), lg)]) begin
      load_sample(sb.reverse_bits(k & ((1 << lg) - 1), lg));
    end
    send_item(CMD_READ, k, pick_value(), pick_value());
  endtask

  task automatic transform_phase(logic [3:0] v, int reads);
    int lg, n;
    set_length(v);
    lg = sb.stages();
    n = 1 << lg;
    for (int i = 0; i < n; i++) begin
      if (!sample_written[i] || $urandom_range(0, 1)) load_sample(i);
      if (i < n / 2 && (!twiddle_written[i] || $urandom_range(0, 1))) begin
        load_twiddle(($urandom_range(0, 1) ? MaxPoints/2 : 0) + i);
      end
      if ($urandom_range(0, 9) == 0) load_sample($urandom_range(0, 1023));
      if ($urandom_range(0, 19) == 0) load_twiddle($urandom_range(n / 2, 1023));
    end
    for (int i = 0; i < n / 2; i++) begin
      if (!twiddle_written[i]) load_twiddle(i);
    end
    if ($urandom_range(0, 3) == 0) random_read(lg);
    send_item(CMD_RUN, $urandom_range(0, 1023), pick_value(), pick_value());
    if ($urandom_range(0, 4) == 0) begin
      send_item(CMD_RUN, $urandom_range(0, 1023), pick_value(), pick_value());
    end
    for (int i = 0; i < reads; i++) random_read(lg);
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    cycles = 0;
    items_sent = 0;
    burst_left = 0;
    stall_ctr = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: two-point transform with extreme samples and twiddles
    set_length(4'd1);
    send_item(CMD_LOAD_SAMPLE, 0, 16'sh7fff, -16'sd32768);
    send_item(CMD_LOAD_SAMPLE, 1, -16'sd32768, 16'sh7fff);
    send_item(CMD_LOAD_TWIDDLE, 512, -16'sd32768, -16'sd32768);
    send_item(CMD_LOAD_SAMPLE, 1023, 16'sd0, 16'sd0);
    sample_written[0] = 1'b1;
    sample_written[1] = 1'b1;
    sample_written[1023] = 1'b1;
    twiddle_written[0] = 1'b1;
    send_item(CMD_READ, 1, 16'sd0, 16'sd0);
    send_item(CMD_RUN, 0, 16'sd0, 16'sd0);
    send_item(CMD_READ, 0, 16'sd0, 16'sd0);
    send_item(CMD_READ, 1023, 16'sd0, 16'sd0);
    send_item(CMD_RUN, 1023, -16'sd1, -16'sd1);
    send_item(CMD_READ, 2, 16'sh7fff, 16'sh7fff);
    send_item(CMD_LOAD_TWIDDLE, 0, 16'sh7fff, 16'sd0);
    send_item(CMD_RUN, 5, 16'sd0, 16'sd0);
    send_item(CMD_READ, 1, 16'sd0, 16'sd0);
    transform_phase(4'd0, 4);

    while (items_sent < 900) begin
      case ($urandom_range(0, 9))
        0, 1, 2: transform_phase(4'd2, $urandom_range(2, 8));
        3, 4, 5: transform_phase(4'd3, $urandom_range(4, 12));
        6, 7: transform_phase(4'd4, $urandom_range(6, 20));
        8: transform_phase(4'd1, $urandom_range(1, 4));
        default: transform_phase(4'($urandom_range(5, 7)), $urandom_range(10, 30));
      endcase
    end
    transform_phase(4'd8, 16);
    // length above the maximum saturates: full-length reads
    set_length(4'd15);
    for (int i = 0; i < 40; i++) random_read(sb.stages());

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire

[radix2_dif_fft.f]
+incdir+hw/rtl
hw/rtl/r2f_pkg.sv
hw/rtl/r2f_bfly.sv
hw/rtl/radix2_dif_fft.sv
hw/rtl/r2f_checker.sv
dv/tb.sv
